FILE: rtl/core/ursm_pkg.sv
// Package for the echo ranging scheduler with median filter.
// Holds payload structs, codes, widths and reset values shared by the modules and the bench.
// No dependencies.
`default_nettype none

package ursm_pkg;

  // Field widths.
  localparam int PULSE_W    = 16;
  localparam int WIDTH_W    = 17;
  localparam int DIST_W     = 14;
  localparam int TICK_W     = 8;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Conversion to millimetres: (p * 10 + 29) / 58. The division is a multiply by
  // ceil(2^25 / 58) followed by a shift, exact for every dividend below 2^20.
  localparam int MM_BIAS     = 29;
  localparam int MM_DIVISOR  = 58;
  localparam int DIVIDEND_W  = 20;
  localparam int RECIP_W     = 20;
  localparam int PROD_W      = DIVIDEND_W + RECIP_W;
  localparam int MM_SHIFT    = 25;
  localparam logic [RECIP_W-1:0] MM_RECIP = 20'd578525;

  // Default filter depth.
  localparam int WINDOW_SIZE_DEF = 5;

  // Register reset values.
  localparam logic [TICK_W-1:0]  TRIGGER_INTERVAL_RST = 8'd6;
  localparam logic [TICK_W-1:0]  ECHO_TIMEOUT_RST     = 8'd3;
  localparam logic [PULSE_W-1:0] MIN_PULSE_RST        = 16'd116;
  localparam logic [PULSE_W-1:0] MAX_PULSE_RST        = 16'd26100;
  localparam logic [PULSE_W-1:0] COUNTER_PERIOD_RST   = 16'd65535;
  localparam logic [TICK_W-1:0]  TICK_SAT             = 8'd255;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_INTERVAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ECHO_TIMEOUT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNTER_PERIOD   = 3'd4;

  // Item kinds.
  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_CAPTURE = 1'b1;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_WAITING = 2'd0;
  localparam logic [STATUS_W-1:0] ST_VALID   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT = 2'd3;

  // Measurement phase.
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WAIT = 2'd1,
    PH_CAPT = 2'd2
  } phase_t;

  // Sequencer of the long (filtering) path.
  typedef enum logic [1:0] {
    SQ_READY = 2'd0,
    SQ_DIV   = 2'd1,
    SQ_MED   = 2'd2,
    SQ_DONE  = 2'd3
  } seq_state_t;

  // Channel payloads.
  typedef struct packed {
    logic               opcode;
    logic [PULSE_W-1:0] rise_count;
    logic [PULSE_W-1:0] fall_count;
  } in_item_t;

  typedef struct packed {
    logic                trigger_now;
    logic                result_new;
    logic [DIST_W-1:0]   distance_out;
    logic [STATUS_W-1:0] status_out;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_item_t;

  // Divider request and response.
  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIST_W-1:0] quotient;
  } div_rsp_t;

  // Median filter request and response.
  typedef struct packed {
    logic              push;
    logic [DIST_W-1:0] value;
  } med_req_t;

  typedef struct packed {
    logic              done;
    logic [DIST_W-1:0] median;
  } med_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/core/ursm_chan_if.sv
// Valid/ready channel interface carrying one payload of a given type.
// Used for the input, result and configuration channels; no dependencies.
`default_nettype none

interface ursm_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/ursm_div58.sv
// Division by the constant 58 through a reciprocal multiply; the dividend and then the quotient are registered.
// Depends on ursm_pkg for widths, the reciprocal and the request/response structs.
`default_nettype none

module ursm_div58 (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ursm_pkg::div_req_t req,
  output ursm_pkg::div_rsp_t      rsp
);

  logic [ursm_pkg::DIVIDEND_W-1:0] dvd_r;
  logic [ursm_pkg::DIST_W-1:0]     quo_r;
  logic                            mul_r;
  logic                            done_r;
  logic [ursm_pkg::PROD_W-1:0]     prod;

  // Fixed-point product; the quotient starts at the shift position.
  assign prod = ursm_pkg::PROD_W'(dvd_r) * ursm_pkg::PROD_W'(ursm_pkg::MM_RECIP);

  // Control flags: dividend captured, then quotient ready in the cycle after.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      mul_r  <= req.start;
      done_r <= mul_r;
    end
  end

  // Datapath: register the dividend, then the shifted product.
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
    end
    if (mul_r) begin
      quo_r <= prod[ursm_pkg::MM_SHIFT +: ursm_pkg::DIST_W];
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

`default_nettype wire

FILE: rtl/core/ursm_median.sv
// Running median window: stores the latest distances and finds the upper
// median by a rank sweep, one candidate per cycle. Depends on ursm_pkg.
`default_nettype none

module ursm_median #(
  parameter int WINDOW_SIZE = ursm_pkg::WINDOW_SIZE_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ursm_pkg::med_req_t req,
  output ursm_pkg::med_rsp_t      rsp
);

  localparam int IW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int CW = $clog2(WINDOW_SIZE + 1);

  logic [ursm_pkg::DIST_W-1:0] win_r [WINDOW_SIZE];
  logic [IW-1:0]               slot_r;
  logic [CW-1:0]               fill_r;
  logic [IW-1:0]               k_r;
  logic                        busy_r;
  logic                        done_r;
  logic [ursm_pkg::DIST_W-1:0] median_r;
  logic [ursm_pkg::DIST_W-1:0] cand;
  logic [CW-1:0]               rank;
  logic                        hit;

  // Rank of the candidate in a stable sort of the held values.
  assign cand = win_r[k_r];

  always_comb begin
    rank = '0;
    for (int j = 0; j < WINDOW_SIZE; j++) begin
      if ((CW'(j) < fill_r) &&
          ((win_r[j] < cand) || ((IW'(j) < k_r) && (win_r[j] == cand)))) begin
        rank = rank + CW'(1);
      end
    end
  end

  assign hit = (rank == (fill_r >> 1));

  // Window store, written at the rolling slot.
  always_ff @(posedge clk) begin
    if (req.push) begin
      win_r[slot_r] <= req.value;
    end
  end

  // Slot, fill count and sweep control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      fill_r <= '0;
      k_r    <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.push) begin
        slot_r <= (slot_r == IW'(WINDOW_SIZE - 1)) ? '0 : slot_r + IW'(1);
        if (fill_r != CW'(WINDOW_SIZE)) begin
          fill_r <= fill_r + CW'(1);
        end
        k_r    <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (hit) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          k_r <= k_r + IW'(1);
        end
      end
    end
  end

  // Captured median value.
  always_ff @(posedge clk) begin
    if (busy_r && hit) begin
      median_r <= cand;
    end
  end

  assign rsp.done   = done_r;
  assign rsp.median = median_r;

endmodule

`default_nettype wire

FILE: rtl/core/ultrasonic_range_scheduler_median.sv
// Echo ranging scheduler with a running median of accepted distances.
// A result is offered in the cycle after its input transfer, except for a tick that closes
// an in-range capture, which waits for the reciprocal divide, the median sweep (0 to n-1
// rank steps, n = values held) and the final hand-over; it blocks input until then.
// Throughput: one item per cycle for plain items while the result register is not stalled.
// Reset (synchronous, active low) restores register defaults and clears the filter.
`default_nettype none

module ultrasonic_range_scheduler_median #(
  parameter int WINDOW_SIZE = ursm_pkg::WINDOW_SIZE_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ursm_chan_if.sink   in_if,
  ursm_chan_if.source out_if,
  ursm_chan_if.sink   cfg_if
);

  // Configuration registers.
  logic [ursm_pkg::TICK_W-1:0]  trig_int_r;
  logic [ursm_pkg::TICK_W-1:0]  echo_to_r;
  logic [ursm_pkg::PULSE_W-1:0] min_pulse_r;
  logic [ursm_pkg::PULSE_W-1:0] max_pulse_r;
  logic [ursm_pkg::PULSE_W-1:0] period_r;

  // Measurement state.
  ursm_pkg::phase_t               phase_r, phase_nxt;
  logic [ursm_pkg::WIDTH_W-1:0]   pulse_w_r, pulse_w_nxt;
  logic [ursm_pkg::TICK_W-1:0]    idle_ticks_r, idle_ticks_nxt;
  logic [ursm_pkg::TICK_W-1:0]    wait_ticks_r, wait_ticks_nxt;
  logic [ursm_pkg::DIST_W-1:0]    last_dist_r;
  logic [ursm_pkg::STATUS_W-1:0]  last_status_r, last_status_nxt;

  // Sequencer and result register.
  ursm_pkg::seq_state_t seq_r, seq_nxt;
  logic                 out_valid_r;
  ursm_pkg::out_item_t  out_item_r;

  logic                 in_fire;
  logic                 out_free;
  logic                 in_ready;
  logic                 load_long;
  logic                 item_trig;
  logic                 item_fresh;
  logic                 item_long;
  ursm_pkg::in_item_t   item;
  ursm_pkg::div_req_t   div_req;
  ursm_pkg::div_rsp_t   div_rsp;
  ursm_pkg::med_req_t   med_req;
  ursm_pkg::med_rsp_t   med_rsp;

  assign item     = in_if.payload;
  assign out_free = !out_valid_r || out_if.ready;
  assign in_fire  = in_if.valid && in_ready;

  // Configuration writes; an unknown index is dropped.
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_int_r  <= ursm_pkg::TRIGGER_INTERVAL_RST;
      echo_to_r   <= ursm_pkg::ECHO_TIMEOUT_RST;
      min_pulse_r <= ursm_pkg::MIN_PULSE_RST;
      max_pulse_r <= ursm_pkg::MAX_PULSE_RST;
      period_r    <= ursm_pkg::COUNTER_PERIOD_RST;
    end else if (cfg_if.valid) begin
      case (cfg_if.payload.reg_index)
        ursm_pkg::CFG_TRIGGER_INTERVAL:
          trig_int_r <= cfg_if.payload.wdata[ursm_pkg::TICK_W-1:0];
        ursm_pkg::CFG_ECHO_TIMEOUT:
          echo_to_r <= cfg_if.payload.wdata[ursm_pkg::TICK_W-1:0];
        ursm_pkg::CFG_MIN_PULSE:      min_pulse_r <= cfg_if.payload.wdata;
        ursm_pkg::CFG_MAX_PULSE:      max_pulse_r <= cfg_if.payload.wdata;
        ursm_pkg::CFG_COUNTER_PERIOD: period_r    <= cfg_if.payload.wdata;
        default: ;
      endcase
    end
  end

  // Item evaluation: next measurement state and the immediate result.
  always_comb begin
    phase_nxt       = phase_r;
    pulse_w_nxt     = pulse_w_r;
    idle_ticks_nxt  = idle_ticks_r;
    wait_ticks_nxt  = wait_ticks_r;
    last_status_nxt = last_status_r;
    item_trig       = 1'b0;
    item_fresh      = 1'b0;
    item_long       = 1'b0;
    if (item.opcode == ursm_pkg::OP_CAPTURE) begin
      // A capture only counts while waiting for the echo.
      if (phase_r == ursm_pkg::PH_WAIT) begin
        if (item.rise_count >= item.fall_count) begin
          pulse_w_nxt = {1'b0, item.rise_count} - {1'b0, item.fall_count};
        end else begin
          pulse_w_nxt = {1'b0, item.rise_count} + {1'b0, period_r}
                      + ursm_pkg::WIDTH_W'(1) - {1'b0, item.fall_count};
        end
        phase_nxt = ursm_pkg::PH_CAPT;
      end
    end else begin
      case (phase_r)
        ursm_pkg::PH_CAPT: begin
          if ((pulse_w_r < {1'b0, min_pulse_r}) || (pulse_w_r > {1'b0, max_pulse_r})) begin
            last_status_nxt = ursm_pkg::ST_RANGE;
            item_fresh      = 1'b1;
          end else begin
            last_status_nxt = ursm_pkg::ST_VALID;
            item_long       = 1'b1;
          end
          idle_ticks_nxt = '0;
          phase_nxt      = ursm_pkg::PH_IDLE;
        end
        ursm_pkg::PH_WAIT: begin
          if (wait_ticks_r != ursm_pkg::TICK_SAT) begin
            wait_ticks_nxt = wait_ticks_r + ursm_pkg::TICK_W'(1);
          end
          if (wait_ticks_nxt >= echo_to_r) begin
            last_status_nxt = ursm_pkg::ST_TIMEOUT;
            item_fresh      = 1'b1;
            idle_ticks_nxt  = '0;
            phase_nxt       = ursm_pkg::PH_IDLE;
          end
        end
        default: begin
          if (idle_ticks_r < trig_int_r) begin
            idle_ticks_nxt = idle_ticks_r + ursm_pkg::TICK_W'(1);
          end
          if (idle_ticks_nxt >= trig_int_r) begin
            wait_ticks_nxt = '0;
            phase_nxt      = ursm_pkg::PH_WAIT;
            item_trig      = 1'b1;
          end
        end
      endcase
    end
  end

  // Measurement state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= ursm_pkg::PH_IDLE;
      pulse_w_r     <= '0;
      idle_ticks_r  <= ursm_pkg::TRIGGER_INTERVAL_RST;
      wait_ticks_r  <= '0;
      last_status_r <= ursm_pkg::ST_WAITING;
    end else if (in_fire) begin
      phase_r       <= phase_nxt;
      pulse_w_r     <= pulse_w_nxt;
      idle_ticks_r  <= idle_ticks_nxt;
      wait_ticks_r  <= wait_ticks_nxt;
      last_status_r <= last_status_nxt;
    end
  end

  // Sequencer: next state.
  always_comb begin
    seq_nxt = seq_r;
    case (seq_r)
      ursm_pkg::SQ_READY: if (in_fire && item_long) seq_nxt = ursm_pkg::SQ_DIV;
      ursm_pkg::SQ_DIV:   if (div_rsp.done)         seq_nxt = ursm_pkg::SQ_MED;
      ursm_pkg::SQ_MED:   if (med_rsp.done)         seq_nxt = ursm_pkg::SQ_DONE;
      ursm_pkg::SQ_DONE:  if (out_free)             seq_nxt = ursm_pkg::SQ_READY;
      default:            seq_nxt = ursm_pkg::SQ_READY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= ursm_pkg::SQ_READY;
    end else begin
      seq_r <= seq_nxt;
    end
  end

  // Sequencer: outputs.
  always_comb begin
    in_ready         = 1'b0;
    load_long        = 1'b0;
    div_req.start    = 1'b0;
    med_req.push     = 1'b0;
    // Dividend p * 10 + 29; an accepted width never exceeds 16 bits.
    div_req.dividend =
        ursm_pkg::DIVIDEND_W'({pulse_w_r[ursm_pkg::PULSE_W-1:0], 3'b000})
      + ursm_pkg::DIVIDEND_W'({pulse_w_r[ursm_pkg::PULSE_W-1:0], 1'b0})
      + ursm_pkg::DIVIDEND_W'(ursm_pkg::MM_BIAS);
    med_req.value    = div_rsp.quotient;
    case (seq_r)
      ursm_pkg::SQ_READY: begin
        in_ready      = out_free;
        div_req.start = in_if.valid && out_free && item_long;
      end
      ursm_pkg::SQ_DIV:  med_req.push = div_rsp.done;
      ursm_pkg::SQ_DONE: load_long    = out_free;
      default: ;
    endcase
  end

  assign in_if.ready = in_ready;

  ursm_div58 u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  ursm_median #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_median (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (med_req),
    .rsp   (med_rsp)
  );

  // Latest published distance.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_dist_r <= '0;
    end else if (load_long) begin
      last_dist_r <= med_rsp.median;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((in_fire && !item_long) || load_long) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_long) begin
      out_item_r.trigger_now  <= 1'b0;
      out_item_r.result_new   <= 1'b1;
      out_item_r.distance_out <= med_rsp.median;
      out_item_r.status_out   <= ursm_pkg::ST_VALID;
    end else if (in_fire && !item_long) begin
      out_item_r.trigger_now  <= item_trig;
      out_item_r.result_new   <= item_fresh;
      out_item_r.distance_out <= last_dist_r;
      out_item_r.status_out   <= last_status_nxt;
    end
  end

  assign out_if.valid   = out_valid_r;
  assign out_if.payload = out_item_r;

endmodule

`default_nettype wire

FILE: rtl/core/ursm_checker.sv
// Port-level checks for the echo ranging scheduler, bound to the top level.
// Depends on ursm_pkg and ultrasonic_range_scheduler_median.
`default_nettype none

module ursm_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire ursm_pkg::out_item_t out_payload
);

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result withdrawn before its transfer");

  // A stalled result keeps its contents.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_payload))
    else $error("stalled result changed");

  // No new item is taken while the result register is blocked.
  a_no_take_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while result stalled");

  // A trigger request and a published outcome never share one result.
  a_trig_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_payload.trigger_now && out_payload.result_new))
    else $error("trigger and outcome in one result");

  // A published outcome always carries a final status.
  a_fresh_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_payload.result_new) |-> (out_payload.status_out != ursm_pkg::ST_WAITING))
    else $error("outcome published with waiting status");

endmodule

bind ultrasonic_range_scheduler_median ursm_checker u_ursm_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .out_payload (out_if.payload)
);

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for the echo ranging scheduler with its running median filter.
// Needs the ursm_pkg package, the ursm_chan_if interface and the block under test.
// A scoreboard class predicts one result per input transfer; plain tasks drive the channels.

module testbench;
  import ursm_pkg::*;

  localparam int WINDOW_DEPTH = WINDOW_SIZE_DEF;

  // Predicts every result of the block and checks what comes out of it.
  class range_scoreboard;
    logic [TICK_W-1:0]   trigger_interval;
    logic [TICK_W-1:0]   echo_timeout;
    logic [PULSE_W-1:0]  min_pulse;
    logic [PULSE_W-1:0]  max_pulse;
    logic [PULSE_W-1:0]  counter_period;
    phase_t              phase;
    logic [WIDTH_W-1:0]  pulse_width;
    logic [DIST_W-1:0]   window [WINDOW_DEPTH];
    int                  fill_count;
    int                  write_slot;
    logic [TICK_W-1:0]   idle_ticks;
    logic [TICK_W-1:0]   wait_ticks;
    logic [DIST_W-1:0]   last_distance;
    logic [STATUS_W-1:0] last_status;
    out_item_t           pending_results [$];
    int                  error_count;

    function new();
      error_count = 0;
      reset_state();
    endfunction

    function void reset_state();
      trigger_interval = TRIGGER_INTERVAL_RST;
      echo_timeout     = ECHO_TIMEOUT_RST;
      min_pulse        = MIN_PULSE_RST;
      max_pulse        = MAX_PULSE_RST;
      counter_period   = COUNTER_PERIOD_RST;
      phase            = PH_IDLE;
      pulse_width      = '0;
      for (int i = 0; i < WINDOW_DEPTH; i++) window[i] = '0;
      fill_count       = 0;
      write_slot       = 0;
      idle_ticks       = TRIGGER_INTERVAL_RST;
      wait_ticks       = '0;
      last_distance    = '0;
      last_status      = ST_WAITING;
    endfunction

    // Register writes take effect at once; unknown indexes change nothing.
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_TRIGGER_INTERVAL: trigger_interval = data[TICK_W-1:0];
        CFG_ECHO_TIMEOUT:     echo_timeout     = data[TICK_W-1:0];
        CFG_MIN_PULSE:        min_pulse        = data;
        CFG_MAX_PULSE:        max_pulse        = data;
        CFG_COUNTER_PERIOD:   counter_period   = data;
        default: ;
      endcase
    endfunction

    // Stores a distance in the ring and returns the upper median of what is held.
    function logic [DIST_W-1:0] push_distance(logic [DIST_W-1:0] d);
      logic [DIST_W-1:0] sorted [WINDOW_DEPTH];
      logic [DIST_W-1:0] v;
      int                j;
      if (write_slot >= WINDOW_DEPTH) write_slot = 0;
      window[write_slot] = d;
      write_slot = (write_slot + 1) % WINDOW_DEPTH;
      if (fill_count < WINDOW_DEPTH) fill_count++;
      for (int i = 0; i < fill_count; i++) sorted[i] = window[i];
      for (int i = 1; i < fill_count; i++) begin
        v = sorted[i];
        j = i;
        while (j > 0 && sorted[j-1] > v) begin
          sorted[j] = sorted[j-1];
          j--;
        end
        sorted[j] = v;
      end
      return sorted[fill_count / 2];
    endfunction

    // Advances the prediction by one accepted input and queues the result it causes.
    function void record_item(in_item_t it);
      out_item_t           outcome;
      logic [WIDTH_W:0]    span;
      int unsigned         millimetres;
      logic                trig;
      logic                fresh;
      trig  = 1'b0;
      fresh = 1'b0;
      if (it.opcode == OP_CAPTURE) begin
        // A capture counts only while an echo is awaited.
        if (phase == PH_WAIT) begin
          if (it.rise_count >= it.fall_count) begin
            pulse_width = it.rise_count - it.fall_count;
          end else begin
            span = (WIDTH_W+1)'(it.rise_count) + (WIDTH_W+1)'(counter_period) + 1
                   - (WIDTH_W+1)'(it.fall_count);
            pulse_width = span[WIDTH_W-1:0];
          end
          phase = PH_CAPT;
        end
      end else if (phase == PH_CAPT) begin
        if (pulse_width < min_pulse || pulse_width > max_pulse) begin
          last_status = ST_RANGE;
        end else begin
          millimetres   = (int'(pulse_width) * 10 + MM_BIAS) / MM_DIVISOR;
          last_distance = push_distance(millimetres[DIST_W-1:0]);
          last_status   = ST_VALID;
        end
        fresh      = 1'b1;
        idle_ticks = '0;
        phase      = PH_IDLE;
      end else if (phase == PH_WAIT) begin
        if (wait_ticks < TICK_SAT) wait_ticks++;
        if (wait_ticks >= echo_timeout) begin
          last_status = ST_TIMEOUT;
          fresh       = 1'b1;
          idle_ticks  = '0;
          phase       = PH_IDLE;
        end
      end else begin
        if (idle_ticks < trigger_interval) idle_ticks++;
        if (idle_ticks >= trigger_interval) begin
          wait_ticks = '0;
          phase      = PH_WAIT;
          trig       = 1'b1;
        end
      end
      outcome.trigger_now  = trig;
      outcome.result_new   = fresh;
      outcome.distance_out = last_distance;
      outcome.status_out   = last_status;
      pending_results.push_back(outcome);
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        error_count++;
      end
    endfunction

    // Compares an accepted result with the oldest prediction.
    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        error_count++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("trigger_now", want.trigger_now, got.trigger_now);
      compare_field("result_new", want.result_new, got.result_new);
      compare_field("distance_out", want.distance_out, got.distance_out);
      compare_field("status_out", want.status_out, got.status_out);
    endfunction
  endclass

  logic clk;
  logic rst_n;

  ursm_chan_if #(.T(in_item_t))  in_ch  ();
  ursm_chan_if #(.T(out_item_t)) out_ch ();
  ursm_chan_if #(.T(cfg_item_t)) cfg_ch ();

  range_scoreboard sb;
  int              send_idle_pct;
  int              recv_idle_pct;
  int              results_seen;

  ultrasonic_range_scheduler_median i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Overall time limit.
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // Result side: checks each transfer and stalls at random, once for a long stretch.
  initial begin
    int hold_left;
    bit hold_done;
    hold_left    = 0;
    hold_done    = 1'b0;
    results_seen = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        sb.check_result(out_ch.payload);
        results_seen++;
      end
      if (!hold_done && results_seen >= 40) begin
        hold_done = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Random gap before an input transfer.
  task automatic sender_gap();
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // Offers one item and waits for its transfer; valid stays high afterwards.
  task automatic send_item(in_item_t it);
    sender_gap();
    in_ch.payload <= it;
    in_ch.valid   <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    sb.record_item(it);
  endtask

  task automatic program_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_item_t w;
    w.reg_index = idx;
    w.wdata     = data;
    cfg_ch.payload <= w;
    cfg_ch.valid   <= 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(idx, data);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  // Waits until every result is out, then rewrites all registers and one unused index.
  task automatic apply_settings(logic [CFG_DATA_W-1:0] interval, logic [CFG_DATA_W-1:0] timeout,
                                logic [CFG_DATA_W-1:0] lo, logic [CFG_DATA_W-1:0] hi,
                                logic [CFG_DATA_W-1:0] period);
    wait_drained();
    program_reg(CFG_TRIGGER_INTERVAL, interval);
    program_reg(CFG_ECHO_TIMEOUT, timeout);
    program_reg(CFG_MIN_PULSE, lo);
    program_reg(CFG_MAX_PULSE, hi);
    program_reg(CFG_COUNTER_PERIOD, period);
    program_reg(CFG_COUNTER_PERIOD + 3'd1 + 3'($urandom_range(2)), 16'($urandom));
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic in_item_t make_item(logic op, logic [PULSE_W-1:0] rise,
                                         logic [PULSE_W-1:0] fall);
    in_item_t it;
    it.opcode     = op;
    it.rise_count = rise;
    it.fall_count = fall;
    return it;
  endfunction

  // Mostly well-formed measurements: captures while an echo is awaited, ticks otherwise.
  function automatic in_item_t random_item();
    in_item_t           it;
    logic [PULSE_W-1:0] w;
    logic [PULSE_W-1:0] lo;
    logic [PULSE_W-1:0] hi;
    int                 sel;
    if (sb.phase == PH_WAIT) it.opcode = ($urandom_range(99) < 65) ? OP_CAPTURE : OP_TICK;
    else                     it.opcode = ($urandom_range(99) < 8) ? OP_CAPTURE : OP_TICK;
    sel = $urandom_range(9);
    if (sel < 6) begin
      // Width within the accepted window (any width if that window is empty), edges without wraparound.
      lo = sb.min_pulse;
      hi = sb.max_pulse;
      if (lo > hi) begin
        lo = '0;
        hi = '1;
      end
      w = 16'($urandom_range(hi, lo));
      it.rise_count = 16'($urandom_range(16'hFFFF, w));
      it.fall_count = it.rise_count - w;
    end else if (sel < 8) begin
      // Counter wrapped between the captured edges.
      it.fall_count = 16'($urandom_range(16'hFFFF, 1));
      it.rise_count = 16'($urandom_range(it.fall_count - 1, 0));
    end else begin
      it.rise_count = 16'($urandom);
      it.fall_count = 16'($urandom);
    end
    return it;
  endfunction

  // Ignored captures do not count towards the requested number of items.
  task automatic run_random(int count);
    in_item_t it;
    int       done_items;
    bit       ignored;
    done_items = 0;
    while (done_items < count) begin
      it      = random_item();
      ignored = (it.opcode == OP_CAPTURE) && (sb.phase != PH_WAIT);
      send_item(it);
      if (!ignored) done_items++;
    end
  endtask

  // Stimulus and end of run.
  initial begin
    sb = new();
    send_idle_pct = 20;
    recv_idle_pct = 68;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.payload  <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.payload <= '0;
    out_ch.ready   <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under reset settings: ignored capture, shortest accepted pulse.
    send_item(make_item(OP_CAPTURE, 16'd1000, 16'd500));
    send_item(make_item(OP_TICK, 16'd0, 16'd0));
    send_item(make_item(OP_CAPTURE, 16'd116, 16'd0));
    send_item(make_item(OP_TICK, 16'hFFFF, 16'hFFFF));
    // Zero interval from here: every idle tick triggers.
    apply_settings(16'd0, ECHO_TIMEOUT_RST, MIN_PULSE_RST, MAX_PULSE_RST, COUNTER_PERIOD_RST);
    // Longest accepted pulse through a wrapped counter, then a capture while captured.
    send_item(make_item(OP_TICK, 16'd0, 16'd0));
    send_item(make_item(OP_CAPTURE, 16'd100, 16'd39536));
    send_item(make_item(OP_CAPTURE, 16'd5, 16'd3));
    send_item(make_item(OP_TICK, 16'd0, 16'd0));
    // One above the maximum, then one below the minimum.
    send_item(make_item(OP_TICK, 16'd0, 16'd0));
    send_item(make_item(OP_CAPTURE, 16'd26101, 16'd0));
    send_item(make_item(OP_TICK, 16'd0, 16'd0));
    send_item(make_item(OP_TICK, 16'd0, 16'd0));
    send_item(make_item(OP_CAPTURE, 16'd115, 16'd0));
    send_item(make_item(OP_TICK, 16'd0, 16'd0));
    // Echo timeout after three waiting ticks.
    send_item(make_item(OP_TICK, 16'd0, 16'd0));
    repeat (3) send_item(make_item(OP_TICK, 16'h5555, 16'hAAAA));
    // Extremes of both counts in one capture.
    send_item(make_item(OP_TICK, 16'd0, 16'd0));
    send_item(make_item(OP_CAPTURE, 16'd0, 16'hFFFF));
    send_item(make_item(OP_TICK, 16'd0, 16'd0));

    // Random part over several register settings.
    apply_settings(16'd1, 16'd3, 16'd116, 16'd26100, 16'hFFFF);
    run_random(80);
    send_idle_pct = 68;
    recv_idle_pct = 20;
    apply_settings(16'd0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
    run_random(80);
    // Minimum above maximum, zero counter period, saturated tick counts.
    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
    run_random(270);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    apply_settings(16'd3, 16'd255, 16'd200, 16'd40000, 16'd1000);
    run_random(60);

    wait_drained();
    repeat (40) @(posedge clk);
    if (sb.error_count == 0 && sb.pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

FILE: filelist.f
rtl/core/ursm_pkg.sv
rtl/core/ursm_chan_if.sv
rtl/core/ursm_div58.sv
rtl/core/ursm_median.sv
rtl/core/ultrasonic_range_scheduler_median.sv
rtl/core/ursm_checker.sv
tb/testbench.sv
